### hdl/vamh_pkg.sv
// ============================================================================
// vamh_pkg
// Shared types and constants for the variable activity max-heap.
// ============================================================================
package vamh_pkg;

    localparam int DEF_MAX_VARS  = 1024;
    localparam int DEF_ACT_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int VAR_W   = 10;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int CFG_W   = 16;
    localparam int FRAC_W  = 16;

    localparam logic [CFG_W-1:0] DECAY_RESET = 16'd64881;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUMP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DECAY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REBUILD = 3'd5;

    // Configuration register indexes
    localparam logic CFG_DECAY    = 1'b0;
    localparam logic CFG_NUM_VARS = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_POP_LAST,
        S_POP_CLR,
        S_SU_RD,
        S_SU_PV,
        S_SU_CMP,
        S_SD_START,
        S_SD_VAR,
        S_SD_VACT,
        S_SD_CHK,
        S_SD_L,
        S_SD_LA,
        S_SD_R,
        S_SD_RC,
        S_RB_NEXT,
        S_DEC_RD,
        S_DEC_MUL,
        S_DEC_WR,
        S_DONE
    } state_t;

endpackage

### hdl/vamh_ram.sv
// ============================================================================
// vamh_ram
// Single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module vamh_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/vamh_scale.sv
// ============================================================================
// vamh_scale
// Decay multiplier: floor(a * d / 2^16), split into high and low partials.
// ============================================================================
module vamh_scale #(
    parameter int ACT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic [ACT_WIDTH-1:0] a,
    input  logic [15:0]          d,
    output logic [ACT_WIDTH-1:0] y
);

    import vamh_pkg::*;

    localparam int EXT_W = ACT_WIDTH + FRAC_W;

    logic [EXT_W-1:0]     a_ext;
    logic [ACT_WIDTH-1:0] a_hi;
    logic [EXT_W-1:0]     p_hi_reg;
    logic [31:0]          p_lo_reg;
    logic [EXT_W-1:0]     sum;

    assign a_ext = {{FRAC_W{1'b0}}, a};
    assign a_hi  = a_ext[EXT_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        p_hi_reg <= EXT_W'(a_hi) * EXT_W'(d);
        p_lo_reg <= 32'(a[FRAC_W-1:0]) * 32'(d);
    end

    assign sum = p_hi_reg + EXT_W'(p_lo_reg[31:FRAC_W]);
    assign y   = sum[ACT_WIDTH-1:0];

endmodule

### hdl/variable_activity_max_heap.sv
// ============================================================================
// variable_activity_max_heap
// Activity-ordered binary max-heap of variables with a slot map, served by
// a sequencer around three RAMs and one decay multiplier.
// ============================================================================
// Operation: insert/bump climb level by level, pop sifts down level by level,
//   decay rescales one variable at a time, rebuild a sift-down per inner node.
// Throughput: one command at a time; sift speed is bound by the RAM read port.
// Reset: a clearing sweep over all MAX_VARS entries zeroes slot map and activities;
//   no command is taken meanwhile, configuration writes are.
module variable_activity_max_heap #(
    parameter int MAX_VARS  = vamh_pkg::DEF_MAX_VARS,
    parameter int ACT_WIDTH = vamh_pkg::DEF_ACT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [vamh_pkg::CFG_W-1:0]    cfg_data,
    // command beat
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vamh_pkg::CMD_W-1:0]    cmd,
    input  logic [vamh_pkg::VAR_W-1:0]    var_index,
    input  logic [vamh_pkg::VALUE_W-1:0]  activity_value,
    // result beat
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [vamh_pkg::VAR_W-1:0]    popped_var,
    output logic [vamh_pkg::COUNT_W-1:0]  heap_count
);

    import vamh_pkg::*;

    localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;  // slot / variable index
    localparam int CW = $clog2(MAX_VARS + 1);                   // count, slot+1
    localparam int IW = AW + 2;                                 // child index math
    localparam int SW = ACT_WIDTH + FRAC_W + 1;                 // bump sum

    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VARS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [CW-1:0]        size_reg, size_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [AW-1:0]        v_reg, v_next;
    logic                 vok_reg, vok_next;
    logic [ACT_WIDTH-1:0] newact_reg, newact_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        var_reg, var_next;          // entry being sifted
    logic [ACT_WIDTH-1:0] var_act_reg, var_act_next;
    logic [AW-1:0]        top_reg, top_next;
    logic [AW-1:0]        lv_reg, lv_next;            // left child or parent
    logic [ACT_WIDTH-1:0] la_reg, la_next;
    logic [AW-1:0]        rv_reg, rv_next;
    logic [AW-1:0]        idx_reg, idx_next;          // clear / decay / rebuild walk
    logic [AW-1:0]        hi_reg, hi_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        popped_reg, popped_next;
    logic [CFG_W-1:0]     decay_reg;
    logic [VAR_W-1:0]     nvars_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [VAR_W-1:0]     out_popped_reg, out_popped_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    logic                 hs_we, sv_we, act_we;
    logic [AW-1:0]        hs_waddr, sv_waddr, act_waddr;
    logic [AW-1:0]        hs_wdata;
    logic [CW-1:0]        sv_wdata;
    logic [ACT_WIDTH-1:0] act_wdata;
    logic [AW-1:0]        hs_raddr, sv_raddr, act_raddr;
    logic [AW-1:0]        hs_rdata;
    logic [CW-1:0]        sv_rdata;
    logic [ACT_WIDTH-1:0] act_rdata;
    logic [ACT_WIDTH-1:0] scale_y;

    vamh_ram #(.DEPTH(MAX_VARS), .DATA_W(AW), .ADDR_W(AW)) u_heap_slots (
        .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
        .raddr(hs_raddr), .rdata(hs_rdata)
    );

    vamh_ram #(.DEPTH(MAX_VARS), .DATA_W(CW), .ADDR_W(AW)) u_slot_of_var (
        .clk(clk), .we(sv_we), .waddr(sv_waddr), .wdata(sv_wdata),
        .raddr(sv_raddr), .rdata(sv_rdata)
    );

    vamh_ram #(.DEPTH(MAX_VARS), .DATA_W(ACT_WIDTH), .ADDR_W(AW)) u_activity (
        .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
        .raddr(act_raddr), .rdata(act_rdata)
    );

    vamh_scale #(.ACT_WIDTH(ACT_WIDTH)) u_scale (
        .clk(clk), .a(act_rdata), .d(decay_reg), .y(scale_y)
    );

    // ------------------------------------------------------------------
    // Shared datapath signals
    // ------------------------------------------------------------------
    logic                 accept;
    logic [IW-1:0]        lft, rgt, sz_ext;
    logic                 has_left, has_right;
    logic [AW-1:0]        parent;
    logic [CW-1:0]        slot_of_pos;
    logic [AW-1:0]        cv;          // chosen child
    logic [ACT_WIDTH-1:0] ca;
    logic [AW-1:0]        pick;
    logic                 sd_move, su_move;
    logic [SW-1:0]        bump_sum;
    logic [ACT_WIDTH-1:0] bump_act;
    logic                 in_heap;
    logic [AW-1:0]        hi_calc;
    logic                 out_free;
    state_t               sd_ret;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign lft       = {1'b0, pos_reg, 1'b1};
    assign rgt       = lft + IW'(1);
    assign sz_ext    = IW'(size_reg);
    assign has_left  = lft < sz_ext;
    assign has_right = rgt < sz_ext;
    assign parent    = (pos_reg - AW'(1)) >> 1;
    assign slot_of_pos = CW'(pos_reg) + CW'(1);

    // right child wins only when strictly greater than the left one
    always_comb
    begin
        if (state_reg == S_SD_RC && act_rdata > la_reg)
        begin
            cv   = rv_reg;
            ca   = act_rdata;
            pick = AW'(rgt);
        end
        else if (state_reg == S_SD_RC)
        begin
            cv   = lv_reg;
            ca   = la_reg;
            pick = AW'(lft);
        end
        else
        begin
            cv   = lv_reg;
            ca   = act_rdata;
            pick = AW'(lft);
        end
    end

    assign sd_move = ca > var_act_reg;
    assign su_move = var_act_reg > act_rdata;

    // bump: +1.0 with saturation at all ones
    assign bump_sum = SW'(act_rdata) + SW'(32'h0001_0000);
    assign bump_act = (bump_sum[SW-1:ACT_WIDTH] != '0) ? '1 : bump_sum[ACT_WIDTH-1:0];

    assign in_heap = (sv_rdata != '0) && (sv_rdata <= size_reg);

    assign hi_calc = (32'(nvars_reg) > 32'(MAX_VARS - 1)) ? LAST_IDX : AW'(nvars_reg);

    assign sd_ret   = (cmd_reg == CMD_REBUILD) ? S_RB_NEXT : S_DONE;
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                priority case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (vok_reg && sv_rdata == '0 && size_reg < CW'(MAX_VARS))
                        begin
                            state_next = S_SU_RD;
                        end
                    end
                    CMD_POP:
                    begin
                        if (size_reg != '0)
                        begin
                            state_next = S_POP_LAST;
                        end
                    end
                    CMD_BUMP:
                    begin
                        if (vok_reg && in_heap)
                        begin
                            state_next = S_SU_RD;
                        end
                    end
                    CMD_DECAY:
                    begin
                        if (hi_calc != '0)
                        begin
                            state_next = S_DEC_RD;
                        end
                    end
                    CMD_REBUILD:
                    begin
                        state_next = S_RB_NEXT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP_LAST: state_next = S_POP_CLR;
            S_POP_CLR:  state_next = (size_reg > CW'(1)) ? S_SD_CHK : S_DONE;
            S_SU_RD:    state_next = (pos_reg == '0) ? S_DONE : S_SU_PV;
            S_SU_PV:    state_next = S_SU_CMP;
            S_SU_CMP:   state_next = su_move ? S_SU_RD : S_DONE;
            S_SD_START: state_next = S_SD_VAR;
            S_SD_VAR:   state_next = S_SD_VACT;
            S_SD_VACT:  state_next = S_SD_CHK;
            S_SD_CHK:   state_next = has_left ? S_SD_L : sd_ret;
            S_SD_L:     state_next = has_right ? S_SD_R : S_SD_LA;
            S_SD_R:     state_next = S_SD_RC;
            S_SD_LA,
            S_SD_RC:    state_next = sd_move ? S_SD_CHK : sd_ret;
            S_RB_NEXT:  state_next = (idx_reg == '0) ? S_DONE : S_SD_START;
            S_DEC_RD:   state_next = S_DEC_MUL;
            S_DEC_MUL:  state_next = S_DEC_WR;
            S_DEC_WR:   state_next = (idx_reg == hi_reg) ? S_DONE : S_DEC_RD;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        size_next       = size_reg;
        cmd_next        = cmd_reg;
        v_next          = v_reg;
        vok_next        = vok_reg;
        newact_next     = newact_reg;
        pos_next        = pos_reg;
        var_next        = var_reg;
        var_act_next    = var_act_reg;
        top_next        = top_reg;
        lv_next         = lv_reg;
        la_next         = la_reg;
        rv_next         = rv_reg;
        idx_next        = idx_reg;
        hi_next         = hi_reg;
        found_next      = found_reg;
        popped_next     = popped_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_found_next  = out_found_reg;
        out_popped_next = out_popped_reg;
        out_count_next  = out_count_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd;
                    v_next      = AW'(var_index);
                    vok_next    = 32'(var_index) < 32'(MAX_VARS);
                    newact_next = ACT_WIDTH'(activity_value);
                    found_next  = 1'b0;
                    popped_next = '0;
                end
            end
            S_DECODE:
            begin
                priority case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (vok_reg && sv_rdata == '0 && size_reg < CW'(MAX_VARS))
                        begin
                            size_next    = size_reg + CW'(1);
                            pos_next     = AW'(size_reg);
                            var_next     = v_reg;
                            var_act_next = act_rdata;
                        end
                    end
                    CMD_POP:
                    begin
                        if (size_reg != '0)
                        begin
                            top_next  = hs_rdata;
                            size_next = size_reg - CW'(1);
                        end
                    end
                    CMD_BUMP:
                    begin
                        pos_next     = AW'(sv_rdata - CW'(1));
                        var_next     = v_reg;
                        var_act_next = bump_act;
                    end
                    CMD_DECAY:
                    begin
                        idx_next = AW'(1);
                        hi_next  = hi_calc;
                    end
                    CMD_REBUILD:
                    begin
                        idx_next = AW'(size_reg >> 1);
                    end
                    default:
                    begin
                        idx_next = idx_reg;
                    end
                endcase
            end
            S_POP_LAST:
            begin
                var_next = hs_rdata;
            end
            S_POP_CLR:
            begin
                found_next   = 1'b1;
                popped_next  = top_reg;
                var_act_next = act_rdata;
                pos_next     = '0;
            end
            S_SU_PV:
            begin
                lv_next = hs_rdata;
            end
            S_SU_CMP:
            begin
                if (su_move)
                begin
                    pos_next = parent;
                end
            end
            S_SD_VAR:
            begin
                var_next = hs_rdata;
            end
            S_SD_VACT:
            begin
                var_act_next = act_rdata;
            end
            S_SD_L:
            begin
                lv_next = hs_rdata;
            end
            S_SD_R:
            begin
                la_next = act_rdata;
                rv_next = hs_rdata;
            end
            S_SD_LA,
            S_SD_RC:
            begin
                if (sd_move)
                begin
                    pos_next = pick;
                end
            end
            S_RB_NEXT:
            begin
                if (idx_reg != '0)
                begin
                    pos_next = idx_reg - AW'(1);
                    idx_next = idx_reg - AW'(1);
                end
            end
            S_DEC_WR:
            begin
                idx_next = idx_reg + AW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_popped_next = VAR_W'(popped_reg);
                    out_count_next  = COUNT_W'(size_reg);
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // RAM controls
    // ------------------------------------------------------------------
    always_comb
    begin
        hs_we     = 1'b0;
        hs_waddr  = pos_reg;
        hs_wdata  = var_reg;
        sv_we     = 1'b0;
        sv_waddr  = var_reg;
        sv_wdata  = slot_of_pos;
        act_we    = 1'b0;
        act_waddr = v_reg;
        act_wdata = bump_act;
        hs_raddr  = '0;
        sv_raddr  = AW'(var_index);
        act_raddr = AW'(var_index);

        unique case (state_reg)
            S_CLEAR:
            begin
                sv_we     = 1'b1;
                sv_waddr  = idx_reg;
                sv_wdata  = '0;
                act_we    = 1'b1;
                act_waddr = idx_reg;
                act_wdata = '0;
            end
            S_DECODE:
            begin
                if (cmd_reg == CMD_POP)
                begin
                    hs_raddr = AW'(size_reg - CW'(1));
                end
                if (cmd_reg == CMD_BUMP && vok_reg)
                begin
                    act_we = 1'b1;
                end
                if (cmd_reg == CMD_SET && vok_reg)
                begin
                    act_we    = 1'b1;
                    act_wdata = newact_reg;
                end
            end
            S_POP_LAST:
            begin
                hs_we     = 1'b1;
                hs_waddr  = '0;
                hs_wdata  = hs_rdata;
                sv_we     = 1'b1;
                sv_waddr  = hs_rdata;
                sv_wdata  = CW'(1);
                act_raddr = hs_rdata;
            end
            S_POP_CLR:
            begin
                sv_we    = 1'b1;
                sv_waddr = top_reg;
                sv_wdata = '0;
            end
            S_SU_RD:
            begin
                hs_raddr = parent;
                if (pos_reg == '0)
                begin
                    hs_we = 1'b1;
                    sv_we = 1'b1;
                end
            end
            S_SU_PV:
            begin
                act_raddr = hs_rdata;
            end
            S_SU_CMP:
            begin
                hs_we = 1'b1;
                sv_we = 1'b1;
                if (su_move)
                begin
                    hs_wdata = lv_reg;
                    sv_waddr = lv_reg;
                end
            end
            S_SD_START:
            begin
                hs_raddr = pos_reg;
            end
            S_SD_VAR:
            begin
                act_raddr = hs_rdata;
            end
            S_SD_CHK:
            begin
                hs_raddr = AW'(lft);
                if (!has_left)
                begin
                    hs_we = 1'b1;
                    sv_we = 1'b1;
                end
            end
            S_SD_L:
            begin
                act_raddr = hs_rdata;
                hs_raddr  = AW'(rgt);
            end
            S_SD_R:
            begin
                act_raddr = hs_rdata;
            end
            S_SD_LA,
            S_SD_RC:
            begin
                hs_we = 1'b1;
                sv_we = 1'b1;
                if (sd_move)
                begin
                    hs_wdata = cv;
                    sv_waddr = cv;
                end
            end
            S_DEC_RD:
            begin
                act_raddr = idx_reg;
            end
            S_DEC_WR:
            begin
                act_we    = 1'b1;
                act_waddr = idx_reg;
                act_wdata = scale_y;
            end
            default:
            begin
                hs_raddr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            size_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers, taken in any state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
            nvars_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DECAY:    decay_reg <= cfg_data;
                CFG_NUM_VARS: nvars_reg <= cfg_data[VAR_W-1:0];
                default:      decay_reg <= decay_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        v_reg          <= v_next;
        vok_reg        <= vok_next;
        newact_reg     <= newact_next;
        pos_reg        <= pos_next;
        var_reg        <= var_next;
        var_act_reg    <= var_act_next;
        top_reg        <= top_next;
        lv_reg         <= lv_next;
        la_reg         <= la_next;
        rv_reg         <= rv_next;
        hi_reg         <= hi_next;
        found_reg      <= found_next;
        popped_reg     <= popped_next;
        out_found_reg  <= out_found_next;
        out_popped_reg <= out_popped_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign popped_var = out_popped_reg;
    assign heap_count = out_count_reg;

endmodule

### tb/variable_activity_max_heap_tb.sv
// ============================================================================
// variable_activity_max_heap_tb
// Self-checking bench for the activity max-heap: each accepted command beat is
// run through an in-bench heap predictor and each result beat is compared with
// the oldest predicted result, with random command gaps and random result stalls.
// ============================================================================
module variable_activity_max_heap_tb;
    import vamh_pkg::*;

    localparam int NVARS      = DEF_MAX_VARS;
    localparam int LIMIT      = 20_000_000;
    localparam int HOLD_LEN   = 600;
    localparam int RAND_ITEMS = 400;
    localparam int FULL_POPS  = 96;

    typedef struct packed {
        logic               found;
        logic [VAR_W-1:0]   var_id;
        logic [COUNT_W-1:0] count;
    } heap_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_DECAY;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd = CMD_INSERT;
    logic [VAR_W-1:0]    var_index = '0;
    logic [VALUE_W-1:0]  activity_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                found;
    logic [VAR_W-1:0]    popped_var;
    logic [COUNT_W-1:0]  heap_count;

    // predictor state
    logic [VAR_W-1:0]    p_heap [NVARS];
    int unsigned         p_slot [NVARS];     // slot + 1, 0 = absent
    logic [31:0]         p_act  [NVARS];
    int unsigned         p_size;
    logic [CFG_W-1:0]    p_decay;
    int unsigned         p_nvars;

    heap_result_t        pending_results [$];
    int                  mismatches = 0;
    int                  beats_sent = 0;
    int                  beats_checked = 0;
    int                  pops_found = 0;
    longint              cycles = 0;
    bit                  no_gaps = 1'b0;     // stretches with no idling
    bit                  long_hold_req = 1'b0;

    variable_activity_max_heap u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .var_index(var_index), .activity_value(activity_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .popped_var(popped_var), .heap_count(heap_count)
    );

    always #5 clk = ~clk;

    // Watchdog: any hang ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: heap moves, written over the bench's own state copy
    // ------------------------------------------------------------------
    task automatic climb(input int unsigned start);
        int unsigned pos;
        int unsigned par;
        logic [VAR_W-1:0] v;
        logic [VAR_W-1:0] pv;
        pos = start;
        v = p_heap[pos];
        while (pos > 0)
        begin
            par = (pos - 1) / 2;
            pv = p_heap[par];
            if (!(p_act[v] > p_act[pv]))
                break;
            p_heap[pos] = pv;
            p_slot[pv] = pos + 1;
            pos = par;
        end
        p_heap[pos] = v;
        p_slot[v] = pos + 1;
    endtask

    task automatic sink(input int unsigned start);
        int unsigned pos;
        int unsigned lft;
        int unsigned pick;
        logic [VAR_W-1:0] v;
        logic [VAR_W-1:0] cv;
        pos = start;
        v = p_heap[pos];
        while (pos * 2 + 1 < p_size)
        begin
            lft = pos * 2 + 1;
            pick = lft;
            // right child wins only when strictly ahead of the left one
            if (lft + 1 < p_size && p_act[p_heap[lft + 1]] > p_act[p_heap[lft]])
                pick = lft + 1;
            cv = p_heap[pick];
            if (p_act[cv] <= p_act[v])
                break;
            p_heap[pos] = cv;
            p_slot[cv] = pos + 1;
            pos = pick;
        end
        p_heap[pos] = v;
        p_slot[v] = pos + 1;
    endtask

    task automatic predict_heap_cmd(input logic [CMD_W-1:0] c, input logic [VAR_W-1:0] v,
                                    input logic [VALUE_W-1:0] val);
        heap_result_t r;
        logic [VAR_W-1:0] top;
        logic [VAR_W-1:0] last;
        logic [63:0] a;
        r = '0;
        case (c)
            CMD_INSERT:
                if (p_slot[v] == 0 && p_size < NVARS)
                begin
                    p_heap[p_size] = v;
                    p_size++;
                    climb(p_size - 1);
                end
            CMD_POP:
                if (p_size > 0)
                begin
                    top = p_heap[0];
                    p_size--;
                    last = p_heap[p_size];
                    p_heap[0] = last;
                    p_slot[last] = 1;
                    p_slot[top] = 0;
                    if (p_size > 1)
                        sink(0);
                    r.found = 1'b1;
                    r.var_id = top;
                end
            CMD_BUMP:
            begin
                // +1.0 in Q16.16, saturating at all ones
                p_act[v] = (p_act[v] > 32'hFFFF_FFFF - 32'h1_0000) ? 32'hFFFF_FFFF
                                                                 : p_act[v] + 32'h1_0000;
                if (p_slot[v] != 0 && p_slot[v] <= p_size)
                    climb(p_slot[v] - 1);
            end
            CMD_DECAY:
                // variable 0 is never scaled; heap order is left alone
                for (int i = 1; i <= p_nvars && i < NVARS; i++)
                begin
                    a = (64'(p_act[i] >> 16) * p_decay)
                        + ((64'(p_act[i] & 32'hFFFF) * p_decay) >> 16);
                    p_act[i] = a[31:0];
                end
            CMD_SET:
                p_act[v] = val;
            CMD_REBUILD:
                for (int i = p_size / 2; i > 0; i--)
                    sink(i - 1);
            default: ;
        endcase
        r.count = p_size[COUNT_W-1:0];
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, plus a long counted hold on request
    // ------------------------------------------------------------------
    int hold_left = 0;
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (long_hold_req)
        begin
            long_hold_req <= 1'b0;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (no_gaps)
            out_stall <= 1'b0;
        else if (r < 60)
            out_stall <= 1'b0;
        else if (r < 97)
            out_stall <= 1'b1;
        else
        begin
            hold_left <= $urandom_range(10, 40);
            out_stall <= 1'b1;
        end
    end

    // Checker: every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        heap_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: found=%0d var=%0d count=%0d",
                             found, popped_var, heap_count);
            end
            else
            begin
                e = pending_results.pop_front();
                if (found !== e.found || popped_var !== e.var_id || heap_count !== e.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch at beat %0d: exp found=%0d var=%0d count=%0d,",
                                  " got found=%0d var=%0d count=%0d"},
                                 beats_checked, e.found, e.var_id, e.count,
                                 found, popped_var, heap_count);
                end
                if (e.found)
                    pops_found++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one command beat; returns at the edge that accepted it. in_valid is
    // left high so a back-to-back beat needs no low/high pair in one step.
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [VAR_W-1:0] v,
                            input logic [VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = c;
        var_index = v;
        activity_value = val;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        predict_heap_cmd(c, v, val);
    endtask

    // Drop valid and wait until every prediction has been matched.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_DECAY)
            p_decay = data;
        else
            p_nvars = data[VAR_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        write_reg(CFG_NUM_VARS, 16'd1023);
        send_cmd(CMD_POP, '0, '0);                  // empty pop
        send_cmd(CMD_INSERT, 10'd0, '0);
        send_cmd(CMD_INSERT, 10'd1023, '0);
        send_cmd(CMD_INSERT, 10'd1023, '0);         // already present
        send_cmd(CMD_SET, 10'd1023, 32'hFFFF_FFFF);
        send_cmd(CMD_BUMP, 10'd1023, '0);           // saturates
        send_cmd(CMD_SET, 10'd5, 32'h0000_FFFF);
        send_cmd(CMD_BUMP, 10'd5, 32'hFFFF_FFFF);   // absent variable
        send_cmd(CMD_INSERT, 10'd5, '0);
        send_cmd(CMD_BUMP, 10'd0, '0);              // stays below the saturated var 1023
        send_cmd(CMD_DECAY, '0, '0);                // var 0 stays, 1023 scaled
        send_cmd(CMD_SET, 10'd0, '0);
        send_cmd(CMD_REBUILD, '0, '0);
        send_cmd(3'd6, 10'd3, 32'h1234_5678);       // unused codes
        send_cmd(3'd7, 10'd3, 32'h1234_5678);
        repeat (4) send_cmd(CMD_POP, '0, '0);       // last one on empty
        write_reg(CFG_DECAY, 16'd0);
        send_cmd(CMD_SET, 10'd2, 32'h8000_0000);
        send_cmd(CMD_DECAY, '0, '0);                // zero factor clears
        write_reg(CFG_DECAY, 16'hFFFF);
        send_cmd(CMD_SET, 10'd2, 32'hFFFF_FFFF);
        send_cmd(CMD_DECAY, '0, '0);
        drain();
    endtask

    // Fill every slot, shuffle scores, rebuild and pop the deepest part.
    task automatic test_full_heap();
        no_gaps = 1'b1;
        for (int i = 0; i < NVARS; i++)
            send_cmd(CMD_INSERT, i[VAR_W-1:0], '0);
        send_cmd(CMD_INSERT, 10'd77, '0);           // full
        for (int i = 0; i < 40; i++)
            send_cmd(CMD_SET, VAR_W'($urandom), $urandom);
        send_cmd(CMD_DECAY, '0, '0);
        send_cmd(CMD_REBUILD, '0, '0);
        no_gaps = 1'b0;
        for (int i = 0; i < FULL_POPS; i++)
            send_cmd(CMD_POP, '0, '0);
        drain();
    endtask

    // Weighted random commands over a small variable pool, sometimes the full range.
    task automatic random_phase(input int n, input int pool);
        int r;
        logic [VAR_W-1:0] v;
        logic [CMD_W-1:0] c;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30) c = CMD_INSERT;
            else if (r < 55) c = CMD_POP;
            else if (r < 75) c = CMD_BUMP;
            else if (r < 87) c = CMD_SET;
            else if (r < 93) c = CMD_DECAY;
            else if (r < 98) c = CMD_REBUILD;
            else c = 3'd6 + CMD_W'($urandom_range(0, 1));
            v = ($urandom_range(0, 9) == 0) ? VAR_W'($urandom) : VAR_W'($urandom_range(0, pool));
            if (k % 100 == 50)
                no_gaps = ~no_gaps;
            send_cmd(c, v, ($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(0, 32'h40_0000));
        end
        no_gaps = 1'b0;
    endtask

    // Receiver holds off long while commands keep coming, so the block backs up.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        no_gaps = 1'b1;
        random_phase(60, 31);
        drain();
    endtask

    task automatic test_random();
        write_reg(CFG_DECAY, DECAY_RESET);
        write_reg(CFG_NUM_VARS, 16'd63);
        random_phase(RAND_ITEMS / 4, 63);
        drain();
        write_reg(CFG_DECAY, 16'(($urandom_range(0, 1)) ? 16'h8000 : $urandom));
        write_reg(CFG_NUM_VARS, 16'd0);
        random_phase(RAND_ITEMS / 4, 15);
        drain();
        write_reg(CFG_DECAY, 16'hFFFF);
        write_reg(CFG_NUM_VARS, 16'd1023);
        random_phase(RAND_ITEMS / 4, 127);
        drain();
        write_reg(CFG_DECAY, 16'(($urandom)));
        write_reg(CFG_NUM_VARS, 16'($urandom_range(1, 200)));
        random_phase(RAND_ITEMS / 4, 40);
        drain();
    endtask

    initial
    begin
        p_size = 0;
        p_decay = DECAY_RESET;
        p_nvars = 0;
        for (int i = 0; i < NVARS; i++)
        begin
            p_heap[i] = '0;
            p_slot[i] = 0;
            p_act[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random();
        test_full_heap();
        drain();
        repeat (50) @(posedge clk);

        $display("Covered: %0d commands incl. full heap, decay extremes, rebuilds, long hold",
                 beats_sent);
        $display("Checked %0d result beats (%0d pops with a variable), %0d mismatches",
                 beats_checked, pops_found, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### variable_activity_max_heap.f
hdl/vamh_pkg.sv
hdl/vamh_ram.sv
hdl/vamh_scale.sv
hdl/variable_activity_max_heap.sv
tb/variable_activity_max_heap_tb.sv
